// ===== rtl/grid_max_path_count_macros.svh =====
// Assertion macros shared by the checker files of grid_max_path_count.
// No dependencies; include by bare file name.
`ifndef GRID_MAX_PATH_COUNT_MACROS_SVH
`define GRID_MAX_PATH_COUNT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define GMPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define GMPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/gmpc_pkg.sv =====
// Package for grid_max_path_count: widths, register indexes, line buffer entry type.
// No dependencies.
`timescale 1ns / 1ps

package gmpc_pkg;

   localparam int MAX_COLS   = 16384;
   localparam int COL_W      = $clog2(MAX_COLS);
   localparam int ROW_W      = 16;
   localparam int CFG_COLS_W = 15;
   localparam int CFG_ROWS_W = 16;
   localparam int WEIGHT_W   = 16;
   localparam int SUM_W      = 34;
   localparam int CNT_W      = 14;
   localparam int ENTRY_W    = SUM_W + CNT_W;

   localparam int IN_DATA_W  = 16;
   localparam int OUT_DATA_W = 48;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0]      COUNT_MOD      = CNT_W'(10000);
   localparam logic [CFG_COLS_W-1:0] RESET_COLS     = CFG_COLS_W'(16);
   localparam logic [CFG_ROWS_W-1:0] RESET_ROWS     = CFG_ROWS_W'(16);
   localparam logic [CFG_COLS_W-1:0] MAX_COLS_VALUE = CFG_COLS_W'(MAX_COLS);

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_COLS = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_GRID_ROWS = 1'b1;

   // one line buffer entry: count above sum
   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [SUM_W-1:0] sum;
   } entry_type;

endpackage

// ===== rtl/gmpc_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module gmpc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== rtl/grid_max_path_count.sv =====
// Top level of grid_max_path_count: best monotone path sum and best-path count per cell.
// Depends on gmpc_pkg and gmpc_ram (previous-row line buffer).
//
// Channel  Dir  Transfer when          Contents
// req      in   req_tvalid&req_tready  tdata: cell_value; tuser: grid_start
// rsp      out  rsp_tvalid&rsp_tready  tdata: best_sum, path_count; tlast: is_final
// csr      in   csr_we                 csr_addr: register index; csr_wdata: value
//
// One cell per cycle sustained while rsp does not stall; a cell reaches rsp through the
// work stage (line buffer read issued at transfer) and then the output register;
// the left neighbor is the previous result, fed back into the add-compare through left_ff.
// Reset (synchronous) clears position, left entry and valids; the line buffer is not
// cleared, since every entry is written in a row before the next row reads it.
// A stall on rsp backs up into req_tready through the single work stage.
`timescale 1ns / 1ps

module grid_max_path_count (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [gmpc_pkg::IN_DATA_W-1:0]     req_tdata,   // [15:0] cell_value
   input  logic                               req_tuser,   // [0] grid_start
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [gmpc_pkg::OUT_DATA_W-1:0]    rsp_tdata,   // [33:0] best_sum, [47:34] path_count
   output logic                               rsp_tlast,   // is_final
   // configuration writes
   input  logic                               csr_we,
   input  logic [gmpc_pkg::CSR_ADDR_W-1:0]    csr_addr,
   input  logic [gmpc_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import gmpc_pkg::*;

   // ---------------------------------------------------------------- config
   logic [CFG_COLS_W-1:0] cols_ff;
   logic [CFG_ROWS_W-1:0] rows_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cols_ff <= RESET_COLS;
         rows_ff <= RESET_ROWS;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_GRID_COLS: cols_ff <= csr_wdata[CFG_COLS_W-1:0];
            CSR_GRID_ROWS: rows_ff <= csr_wdata[CFG_ROWS_W-1:0];
            default: ;
         endcase
      end
   end

   // effective sizes: zero acts as one, columns capped at the buffer depth
   logic [CFG_COLS_W-1:0] last_col;
   logic [CFG_ROWS_W-1:0] last_row;

   always_comb begin
      if (cols_ff == '0) begin
         last_col = '0;
      end else if (cols_ff > MAX_COLS_VALUE) begin
         last_col = MAX_COLS_VALUE - CFG_COLS_W'(1);
      end else begin
         last_col = cols_ff - CFG_COLS_W'(1);
      end
      last_row = (rows_ff == '0) ? '0 : rows_ff - CFG_ROWS_W'(1);
   end

   // ---------------------------------------------------------------- handshake
   logic s1_valid_ff;
   logic rsp_valid_ff;
   logic out_free;
   logic s1_fire;
   logic req_xfer;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign s1_fire    = s1_valid_ff && out_free;
   assign req_tready = !s1_valid_ff || s1_fire;
   assign req_xfer   = req_tvalid && req_tready;

   // ---------------------------------------------------------------- position
   logic [COL_W-1:0] col_ff, col_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] acc_col;
   logic [ROW_W-1:0] acc_row;
   logic             acc_final;

   always_comb begin
      // start mark snaps the position to the top-left cell
      acc_col   = req_tuser ? '0 : col_ff;
      acc_row   = req_tuser ? '0 : row_ff;
      acc_final = (acc_row == last_row) && ({1'b0, acc_col} == last_col);
      col_in    = col_ff;
      row_in    = row_ff;
      if (req_xfer) begin
         if ({1'b0, acc_col} >= last_col) begin
            col_in = '0;
            row_in = (acc_row >= last_row) ? '0 : acc_row + ROW_W'(1);
         end else begin
            col_in = acc_col + COL_W'(1);
            row_in = acc_row;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // ---------------------------------------------------------------- line buffer
   entry_type              res;
   logic [ENTRY_W-1:0]     ram_rdata;
   logic [COL_W-1:0]       s1_col_ff;

   gmpc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (MAX_COLS)
   ) u_row_above (
      .clock   (clock),
      .wr_en   (s1_fire),
      .wr_addr (s1_col_ff),
      .wr_data (res),
      .rd_en   (req_xfer),
      .rd_addr (acc_col),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- work stage
   // s1 holds the cell whose above-entry is being read; a write to the same
   // column in the transfer cycle (one-column grid) is forwarded around the RAM.
   logic                s1_valid_in;
   logic [WEIGHT_W-1:0] s1_w_ff;
   logic                s1_row0_ff;
   logic                s1_final_ff;
   logic                s1_fwd_ff;
   entry_type           s1_fwd_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_xfer) begin
         s1_valid_in = 1'b1;
      end else if (s1_fire) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_w_ff        <= req_tdata[WEIGHT_W-1:0];
         s1_col_ff      <= acc_col;
         s1_row0_ff     <= (acc_row == '0);
         s1_final_ff    <= acc_final;
         s1_fwd_ff      <= s1_fire && (s1_col_ff == acc_col);
         s1_fwd_data_ff <= res;
      end
   end

   // left neighbor: result of the previous cell
   entry_type left_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (s1_fire) begin
         left_ff <= res;
      end
   end

   entry_type          up;
   logic               reach;
   logic [SUM_W-1:0]   base;
   logic [CNT_W-1:0]   cnt_sel;
   logic [CNT_W:0]     cnt_sum;
   logic [CNT_W-1:0]   cnt_tie;
   logic               s1_col0;

   always_comb begin
      up      = s1_fwd_ff ? s1_fwd_data_ff : entry_type'(ram_rdata);
      s1_col0 = (s1_col_ff == '0);
      cnt_sum = {1'b0, up.cnt} + {1'b0, left_ff.cnt};
      // both counts are below the modulus, so one subtract suffices
      cnt_tie = (cnt_sum >= {1'b0, COUNT_MOD}) ? CNT_W'(cnt_sum - {1'b0, COUNT_MOD})
                                               : cnt_sum[CNT_W-1:0];
      reach   = 1'b0;
      base    = '0;
      cnt_sel = '0;
      if (s1_w_ff == '0) begin
         reach = 1'b0;                       // blocked
      end else if (s1_row0_ff && s1_col0) begin
         reach   = 1'b1;                     // top-left seed
         cnt_sel = CNT_W'(1);
      end else if (s1_row0_ff) begin
         reach   = (left_ff.sum != '0);
         base    = left_ff.sum;
         cnt_sel = left_ff.cnt;
      end else if (s1_col0) begin
         reach   = (up.sum != '0);
         base    = up.sum;
         cnt_sel = up.cnt;
      end else if (up.sum > left_ff.sum) begin
         reach   = 1'b1;
         base    = up.sum;
         cnt_sel = up.cnt;
      end else if (up.sum < left_ff.sum) begin
         reach   = 1'b1;
         base    = left_ff.sum;
         cnt_sel = left_ff.cnt;
      end else begin
         reach   = (up.sum != '0);           // tie: counts add
         base    = up.sum;
         cnt_sel = cnt_tie;
      end
      res.sum = reach ? base + {{(SUM_W-WEIGHT_W){1'b0}}, s1_w_ff} : '0;
      res.cnt = reach ? cnt_sel : '0;
   end

   // ---------------------------------------------------------------- output register
   logic                  rsp_valid_in;
   logic [OUT_DATA_W-1:0] rsp_data_ff;
   logic                  rsp_last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_fire) begin
         rsp_data_ff <= {res.cnt, res.sum};
         rsp_last_ff <= s1_final_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ===== rtl/gmpc_checker.sv =====
// Port-level checker for grid_max_path_count, bound to the top level.
// Depends on gmpc_pkg and grid_max_path_count_macros.svh.
`timescale 1ns / 1ps
`include "grid_max_path_count_macros.svh"

module gmpc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [gmpc_pkg::OUT_DATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   import gmpc_pkg::*;

   logic [SUM_W-1:0]      chk_sum;
   logic [CNT_W-1:0]      chk_cnt;
   logic [OUT_DATA_W:0]   rsp_bus;
   logic                  rsp_stall;
   logic                  unreach;

   assign chk_sum   = rsp_tdata[SUM_W-1:0];
   assign chk_cnt   = rsp_tdata[OUT_DATA_W-1:SUM_W];
   assign rsp_bus   = {rsp_tlast, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign unreach   = rsp_tvalid && (chk_sum == '0);

   // a stalled result holds
   `GMPC_ASSERT_NEXT(a_hold_valid, clock, reset, rsp_stall, rsp_tvalid, "rsp valid dropped")
   `GMPC_ASSERT_NEXT(a_hold_data, clock, reset, rsp_stall, $stable(rsp_bus), "rsp data not held")

   // count stays reduced modulo 10000
   `GMPC_ASSERT_SAME(a_cnt_range, clock, reset, rsp_tvalid, chk_cnt < COUNT_MOD, "count too large")

   // an unreachable cell carries a zero count (a reachable one may wrap to zero)
   `GMPC_ASSERT_SAME(a_unreach, clock, reset, unreach, chk_cnt == '0, "unreachable with count")

endmodule

bind grid_max_path_count gmpc_checker u_gmpc_checker (.*);
